[rtl/core/frame_unescape_xor_check_core_macros.svh]
// Assertion macros used by the port-level checker of the frame unescape core.
`ifndef FRAME_UNESCAPE_XOR_CHECK_CORE_MACROS_SVH
`define FRAME_UNESCAPE_XOR_CHECK_CORE_MACROS_SVH

// Property checked while out of reset.
`define FUXC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Property checked at every edge, reset included.
`define FUXC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

[rtl/core/fuxc_pkg.sv]
// Types and constants of the frame unescape and XOR check core.
`timescale 1ns / 1ps
`default_nettype none

package fuxc_pkg;

    localparam int MAX_FRAME_BYTES = 4096;
    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int LEN_W = 13;
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    localparam logic [7:0] ESC_BYTE     = 8'h5A;
    localparam logic [7:0] ESC_CODE_STX = 8'h01;
    localparam logic [7:0] STX_BYTE     = 8'h55;
    localparam logic [LEN_W-1:0] MIN_LEN_RESET = LEN_W'(12);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_ESCAPE = 3'd1;
    localparam logic [2:0] ST_ESC_AT_END = 3'd2;
    localparam logic [2:0] ST_TOO_SHORT  = 3'd3;
    localparam logic [2:0] ST_TOO_LONG   = 3'd4;

    typedef struct packed {
        logic [7:0] raw_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic [7:0]       xor_checksum;
        logic [LEN_W-1:0] decoded_length;
        logic [2:0]       frame_status;
    } t_result;

endpackage

`default_nettype wire

[rtl/core/fuxc_in_stage.sv]
// Input register stage: holds one accepted raw byte until the decoder takes it.
`timescale 1ns / 1ps
`default_nettype none

module fuxc_in_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire fuxc_pkg::t_item i_item,
    input  wire logic           i_advance,
    output logic                o_valid,
    output fuxc_pkg::t_item     o_item
);

    logic            r_valid;
    fuxc_pkg::t_item r_item;
    logic            n_valid;
    logic            load;

    assign o_ready = !r_valid || i_advance;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[rtl/core/fuxc_decoder.sv]
// Frame state: unescaping, running XOR, decoded count, sticky error, length limit.
`timescale 1ns / 1ps
`default_nettype none

module fuxc_decoder (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_write,
    input  wire logic [fuxc_pkg::LEN_W-1:0] i_cfg_data,
    input  wire logic                     i_step,
    input  wire fuxc_pkg::t_item          i_item,
    output fuxc_pkg::t_result             o_result
);

    logic                       r_esc;
    logic [7:0]                 r_xor;
    logic [fuxc_pkg::CNT_W-1:0] r_count;
    logic [2:0]                 r_err;
    logic [fuxc_pkg::LEN_W-1:0] r_min_len;

    logic                       n_esc;
    logic [7:0]                 n_xor;
    logic [fuxc_pkg::CNT_W-1:0] n_count;
    logic [2:0]                 n_err;

    logic                       take;
    logic [7:0]                 take_byte;
    logic [2:0]                 status;

    // Decode one raw byte; take marks a decoded byte to fold in.
    always_comb begin
        n_esc     = r_esc;
        n_err     = r_err;
        take      = 1'b0;
        take_byte = i_item.raw_byte;
        if (r_err == fuxc_pkg::ST_OK) begin
            if (r_esc) begin
                n_esc = 1'b0;
                if (i_item.raw_byte == fuxc_pkg::ESC_BYTE) begin
                    take = 1'b1;
                end else if (i_item.raw_byte == fuxc_pkg::ESC_CODE_STX) begin
                    take      = 1'b1;
                    take_byte = fuxc_pkg::STX_BYTE;
                end else begin
                    n_err = fuxc_pkg::ST_BAD_ESCAPE;
                end
            end else if (i_item.raw_byte == fuxc_pkg::ESC_BYTE) begin
                n_esc = 1'b1;
            end else begin
                take = 1'b1;
            end
        end

        n_xor   = r_xor;
        n_count = r_count;
        if (take) begin
            if (r_count >= fuxc_pkg::CNT_MAX) begin
                n_err = fuxc_pkg::ST_TOO_LONG;
            end else begin
                n_xor   = r_xor ^ take_byte;
                n_count = r_count + fuxc_pkg::CNT_W'(1);
            end
        end

        if (n_err != fuxc_pkg::ST_OK) begin
            status = n_err;
        end else if (n_esc) begin
            status = fuxc_pkg::ST_ESC_AT_END;
        end else if (fuxc_pkg::CMP_W'(n_count) < fuxc_pkg::CMP_W'(r_min_len)) begin
            status = fuxc_pkg::ST_TOO_SHORT;
        end else begin
            status = fuxc_pkg::ST_OK;
        end
    end

    assign o_result.xor_checksum   = n_xor;
    assign o_result.decoded_length = fuxc_pkg::LEN_W'(n_count);
    assign o_result.frame_status   = status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc     <= 1'b0;
            r_xor     <= '0;
            r_count   <= '0;
            r_err     <= fuxc_pkg::ST_OK;
            r_min_len <= fuxc_pkg::MIN_LEN_RESET;
        end else begin
            if (i_cfg_write) begin
                r_min_len <= i_cfg_data;
            end
            if (i_step) begin
                if (i_item.last_byte) begin
                    // frame done: back to the cleared state
                    r_esc   <= 1'b0;
                    r_xor   <= '0;
                    r_count <= '0;
                    r_err   <= fuxc_pkg::ST_OK;
                end else begin
                    r_esc   <= n_esc;
                    r_xor   <= n_xor;
                    r_count <= n_count;
                    r_err   <= n_err;
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/fuxc_out_stage.sv]
// Result register: holds one frame result until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none

module fuxc_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire fuxc_pkg::t_result i_result,
    output logic                   o_can_load,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output fuxc_pkg::t_result      o_result
);

    logic              r_valid;
    fuxc_pkg::t_result r_result;
    logic              n_valid;

    assign o_can_load = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

[rtl/core/frame_unescape_xor_check_core.sv]
// Top level of the frame unescape and XOR checksum core.
//
// Input channel (i_in_valid / o_in_ready): one raw frame byte per transfer on
// i_raw_byte, with i_last_byte high on the final byte of a frame. 0x5A 0x5A
// decodes to 0x5A, 0x5A 0x01 to 0x55; 0x5A before any other byte is an error.
// Output channel (o_out_valid / i_out_ready): one result per frame, giving the
// XOR of the decoded bytes, the decoded length (saturating at 4096) and a
// status: ok, bad escape, escape at end, too short, too long.
// Config channel (i_cfg_valid / o_cfg_ready): writes the minimum decoded
// length; always ready. Write it only while no frame is in flight.
// Throughput: one byte per cycle, while a last byte can wait for the result
// register. The input register feeds the decode and count logic, which loads
// the result register once the last byte leaves the input register.
// A stalled receiver holds the result register; bytes that are not the last
// of a frame keep flowing, and a last byte waits in the input register until
// the result register frees.
// Reset (synchronous, active low) drops both valids, clears the frame state
// and sets the minimum length to 12.
`timescale 1ns / 1ps
`default_nettype none

module frame_unescape_xor_check_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [12:0] i_min_decoded_length,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_raw_byte,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_xor_checksum,
    output logic [12:0]      o_decoded_length,
    output logic [2:0]       o_frame_status
);

    fuxc_pkg::t_item   in_item;
    fuxc_pkg::t_item   st_item;
    fuxc_pkg::t_result dec_result;
    fuxc_pkg::t_result out_result;
    logic              st_valid;
    logic              advance;
    logic              out_can_load;

    assign o_cfg_ready       = 1'b1;
    assign in_item.raw_byte  = i_raw_byte;
    assign in_item.last_byte = i_last_byte;

    // a non-final byte gives no result, so it never waits on the output side
    assign advance = st_valid && (!st_item.last_byte || out_can_load);

    fuxc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (st_valid),
        .o_item    (st_item)
    );

    fuxc_decoder u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_write (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_min_decoded_length),
        .i_step      (advance),
        .i_item      (st_item),
        .o_result    (dec_result)
    );

    fuxc_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance && st_item.last_byte),
        .i_result   (dec_result),
        .o_can_load (out_can_load),
        .i_ready    (i_out_ready),
        .o_valid    (o_out_valid),
        .o_result   (out_result)
    );

    assign o_xor_checksum   = out_result.xor_checksum;
    assign o_decoded_length = out_result.decoded_length;
    assign o_frame_status   = out_result.frame_status;

endmodule

`default_nettype wire

[rtl/core/fuxc_checker.sv]
// Port-level checker for the frame unescape core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "frame_unescape_xor_check_core_macros.svh"

module fuxc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [12:0] o_decoded_length,
    input wire logic [2:0]  o_frame_status
);

    `FUXC_ASSERT_ALWAYS(a_reset_drops_valid, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `FUXC_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_frame_status) && $stable(o_decoded_length), "stalled result changed")
    `FUXC_ASSERT(a_status_code, i_clk, i_rst_n, o_out_valid |-> o_frame_status <= fuxc_pkg::ST_TOO_LONG, "status code out of range")
    `FUXC_ASSERT(a_len_bound, i_clk, i_rst_n, o_out_valid |-> 32'(o_decoded_length) <= fuxc_pkg::MAX_FRAME_BYTES, "length above buffer size")
    `FUXC_ASSERT(a_too_long_full, i_clk, i_rst_n, o_out_valid && o_frame_status == fuxc_pkg::ST_TOO_LONG |-> 32'(o_decoded_length) == fuxc_pkg::MAX_FRAME_BYTES, "too long without full buffer")

endmodule

bind frame_unescape_xor_check_core fuxc_checker u_fuxc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_decoded_length (o_decoded_length),
    .o_frame_status   (o_frame_status)
);

`default_nettype wire

[tb/fuxc_frame_checker.sv]
// Frame report checker: watches all channels, predicts each frame report and compares it.
`timescale 1ns / 1ps

module fuxc_frame_checker
    import fuxc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [LEN_W-1:0] i_cfg_min_len,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [7:0]       i_raw_byte,
    input  logic             i_last_byte,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [7:0]       i_xor_checksum,
    input  logic [LEN_W-1:0] i_decoded_length,
    input  logic [2:0]       i_frame_status,
    output int               o_mismatches,
    output int               o_reports_due
);

    // frame state, tracked alongside the core
    logic             esc_seen;
    logic [7:0]       xor_acc;
    logic [CNT_W-1:0] byte_count;
    logic [2:0]       sticky_err;
    logic [LEN_W-1:0] min_len;

    t_result reports_q[$];

    int mismatches = 0;
    int bytes_in   = 0;
    int cfg_writes = 0;
    int in_stalls  = 0;
    int status_hits [5] = '{0, 0, 0, 0, 0};

    task automatic clear_frame();
        esc_seen   = 1'b0;
        xor_acc    = '0;
        byte_count = '0;
        sticky_err = ST_OK;
    endtask

    task automatic count_decoded(input logic [7:0] v);
        if (byte_count >= CNT_MAX) begin
            sticky_err = ST_TOO_LONG;
        end else begin
            xor_acc    = xor_acc ^ v;
            byte_count = byte_count + 1'b1;
        end
    endtask

    task automatic unstuff_byte(input logic [7:0] b, input logic lst);
        t_result rep;
        if (sticky_err == ST_OK) begin
            if (esc_seen) begin
                esc_seen = 1'b0;
                if (b == ESC_BYTE)
                    count_decoded(ESC_BYTE);
                else if (b == ESC_CODE_STX)
                    count_decoded(STX_BYTE);
                else
                    sticky_err = ST_BAD_ESCAPE;
            end else if (b == ESC_BYTE) begin
                esc_seen = 1'b1;
            end else begin
                count_decoded(b);
            end
        end
        if (lst) begin
            rep.xor_checksum   = xor_acc;
            rep.decoded_length = LEN_W'(byte_count);
            if (sticky_err != ST_OK)
                rep.frame_status = sticky_err;
            else if (esc_seen)
                rep.frame_status = ST_ESC_AT_END;
            else if (CMP_W'(byte_count) < CMP_W'(min_len))
                rep.frame_status = ST_TOO_SHORT;
            else
                rep.frame_status = ST_OK;
            status_hits[rep.frame_status]++;
            reports_q.push_back(rep);
            clear_frame();
        end
    endtask

    task automatic check_report();
        t_result want;
        if (reports_q.size() == 0) begin
            $error("frame report with none outstanding: xor %02h, length %0d, status %0d",
                   i_xor_checksum, i_decoded_length, i_frame_status);
            mismatches++;
        end else begin
            want = reports_q.pop_front();
            if (i_xor_checksum !== want.xor_checksum) begin
                $error("xor_checksum: expected %02h, got %02h",
                       want.xor_checksum, i_xor_checksum);
                mismatches++;
            end
            if (i_decoded_length !== want.decoded_length) begin
                $error("decoded_length: expected %0d, got %0d",
                       want.decoded_length, i_decoded_length);
                mismatches++;
            end
            if (i_frame_status !== want.frame_status) begin
                $error("frame_status: expected %0d, got %0d",
                       want.frame_status, i_frame_status);
                mismatches++;
            end
        end
    endtask

    task automatic print_summary();
        $display("frame reports: ok %0d, bad escape %0d, escape at end %0d, too short %0d, too long %0d",
                 status_hits[ST_OK], status_hits[ST_BAD_ESCAPE], status_hits[ST_ESC_AT_END],
                 status_hits[ST_TOO_SHORT], status_hits[ST_TOO_LONG]);
        $display("%0d bytes in, %0d min length writes, %0d cycles with input held off",
                 bytes_in, cfg_writes, in_stalls);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame();
            min_len = MIN_LEN_RESET;
            reports_q.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_report();
            if (i_cfg_valid && i_cfg_ready) begin
                min_len = i_cfg_min_len;
                cfg_writes++;
            end
            if (i_in_valid && i_in_ready) begin
                unstuff_byte(i_raw_byte, i_last_byte);
                bytes_in++;
            end else if (i_in_valid) begin
                in_stalls++;
            end
        end
        o_reports_due <= reports_q.size();
        o_mismatches  <= mismatches;
    end

endmodule

[tb/tb.sv]
// Testbench top: drives frames and min length writes into the unescape core and gives the verdict.
`timescale 1ns / 1ps

module tb;
    import fuxc_pkg::*;

    localparam int RANDOM_ITEMS = 900;
    localparam int PHASES       = 8;
    localparam int HOLD_CYCLES  = 400;
    // longest quiet stretch: receiver hold plus a long gap, with a wide margin
    localparam int IDLE_LIMIT   = 5000;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_valid   = 1'b0;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_min_len = '0;
    logic             in_valid    = 1'b0;
    logic             in_ready;
    logic [7:0]       raw_byte    = '0;
    logic             last_byte   = 1'b0;
    logic             out_valid;
    logic             out_ready   = 1'b0;
    logic [7:0]       xor_checksum;
    logic [LEN_W-1:0] decoded_length;
    logic [2:0]       frame_status;

    int mismatches;
    int reports_due;

    logic       sender_calm  = 1'b0;
    int         hold_asks    = 0;
    int         hold_seen    = 0;
    int         rx_hold_left = 0;
    int         rx_cycle     = 0;
    int         quiet_cycles = 0;
    int         frame_live   = 0;
    logic [7:0] frame_q[$];

    frame_unescape_xor_check_core uut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (cfg_ready),
        .i_min_decoded_length (cfg_min_len),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_raw_byte           (raw_byte),
        .i_last_byte          (last_byte),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_xor_checksum       (xor_checksum),
        .o_decoded_length     (decoded_length),
        .o_frame_status       (frame_status)
    );

    fuxc_frame_checker chk (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_min_len    (cfg_min_len),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_raw_byte       (raw_byte),
        .i_last_byte      (last_byte),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_xor_checksum   (xor_checksum),
        .i_decoded_length (decoded_length),
        .i_frame_status   (frame_status),
        .o_mismatches     (mismatches),
        .o_reports_due    (reports_due)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // mostly short pauses, a few long ones
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // receiver: random stalls, calm stretches, and a long hold on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (hold_asks != hold_seen) begin
                hold_seen    = hold_asks;
                rx_hold_left = HOLD_CYCLES;
            end else if (rx_hold_left == 0 && ((rx_cycle / 512) % 3) != 0
                         && $urandom_range(0, 3) == 0) begin
                rx_hold_left = pause_len();
            end
            if (rx_hold_left > 0) begin
                out_ready <= 1'b0;
                rx_hold_left--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d reports outstanding",
                     quiet_cycles, reports_due);
            $display("frame_unescape_xor_check_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap;
        gap = sender_calm ? 0 : pause_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        raw_byte  <= b;
        last_byte <= lst;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic ship_frame();
        for (int k = 0; k < frame_q.size(); k++)
            send_byte(frame_q[k], k == frame_q.size() - 1);
        frame_q.delete();
    endtask

    task automatic put(input logic [7:0] b);
        frame_q.push_back(b);
    endtask

    // escape a decoded byte; 0x55 goes out either plain or escaped
    task automatic put_decoded(input logic [7:0] v);
        if (v == ESC_BYTE) begin
            put(ESC_BYTE);
            put(ESC_BYTE);
        end else if (v == STX_BYTE && $urandom_range(0, 1) == 1) begin
            put(ESC_BYTE);
            put(ESC_CODE_STX);
        end else begin
            put(v);
        end
    endtask

    function automatic logic [7:0] pick_decoded();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return ESC_BYTE;
        else if (r == 1)
            return STX_BYTE;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] bad_code();
        logic [7:0] v;
        do v = 8'($urandom_range(0, 255)); while (v == ESC_BYTE || v == ESC_CODE_STX);
        return v;
    endfunction

    task automatic build_random_frame();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        n    = $urandom_range(1, 24);
        if (kind < 12) begin
            // escape-heavy noise
            repeat ($urandom_range(1, 20))
                put(($urandom_range(0, 3) == 0) ? ESC_BYTE : 8'($urandom_range(0, 255)));
            frame_live = frame_q.size();
        end else begin
            repeat (n) put_decoded(pick_decoded());
            frame_live = frame_q.size();
            if (kind < 24) begin
                put(ESC_BYTE);
                put(bad_code());
                frame_live += 2;
                // ignored after the error
                repeat ($urandom_range(0, 6))
                    put(($urandom_range(0, 1) == 0) ? ESC_BYTE : 8'($urandom_range(0, 255)));
            end else if (kind < 32) begin
                put(ESC_BYTE);
                frame_live++;
            end
        end
    endtask

    // wait for all reports, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (reports_due != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_min_len(input logic [LEN_W-1:0] v);
        drain();
        cfg_valid   <= 1'b1;
        cfg_min_len <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int random_items;
        int phase_end;
        int phase;
        logic [LEN_W-1:0] lim;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // min length still at its reset value of 12
        put(ESC_BYTE); put(ESC_BYTE); put(ESC_BYTE); put(ESC_CODE_STX);
        put(8'h00); put(8'hFF); put(8'h80); put(8'h7F);
        ship_frame();
        // bad escape, then bytes that must be ignored
        put(8'h11); put(ESC_BYTE); put(8'h02); put(ESC_BYTE); put(8'h33);
        ship_frame();
        put(8'h22); put(ESC_BYTE);
        ship_frame();
        put(ESC_BYTE);
        ship_frame();
        put(8'h00);
        ship_frame();

        write_min_len('0);
        put(8'hFF);
        ship_frame();
        put(ESC_BYTE); put(ESC_CODE_STX);
        ship_frame();
        put(ESC_BYTE); put(8'h00);
        ship_frame();

        // buffer limits: exactly full, overflow, and a minimum above the buffer
        write_min_len(LEN_W'(MAX_FRAME_BYTES));
        repeat (MAX_FRAME_BYTES) put_decoded(pick_decoded());
        ship_frame();
        repeat (MAX_FRAME_BYTES) put_decoded(pick_decoded());
        put(ESC_BYTE); put(ESC_CODE_STX); put(8'h00);
        ship_frame();
        write_min_len('1);
        repeat (MAX_FRAME_BYTES - 1) put_decoded(pick_decoded());
        ship_frame();
        repeat (MAX_FRAME_BYTES + 3) put(8'($urandom_range(0, 255)));
        ship_frame();

        random_items = 0;
        phase        = 0;
        while (random_items < RANDOM_ITEMS) begin
            case (phase % PHASES)
                0:       lim = '0;
                1:       lim = MIN_LEN_RESET;
                default: lim = LEN_W'($urandom_range(1, 20));
            endcase
            write_min_len(lim);
            sender_calm = (phase % 3 == 2);
            // long receiver hold while the sender keeps pushing
            if (phase == 2 || phase == 5)
                hold_asks++;
            phase_end = random_items + RANDOM_ITEMS / PHASES;
            while (random_items < phase_end) begin
                build_random_frame();
                random_items += frame_live;
                ship_frame();
            end
            phase++;
        end

        drain();
        chk.print_summary();
        if (mismatches == 0)
            $display("frame_unescape_xor_check_core verification clean");
        else
            $display("frame_unescape_xor_check_core verification failed");
        $finish;
    end

endmodule
